[rtl/tfl_pkg.sv]
// ----------------------------------------------------------------------------
// tfl_pkg
// Shared types, register indexes and constants of the tilt filter and
// balance controller.
// ----------------------------------------------------------------------------
package tfl_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_GAIN_ANGLE    = 3'd0;
  localparam logic [2:0] REG_GAIN_RATE     = 3'd1;
  localparam logic [2:0] REG_GAIN_SPEED    = 3'd2;
  localparam logic [2:0] REG_GAIN_INTEGRAL = 3'd3;
  localparam logic [2:0] REG_ANGLE_OFFSET  = 3'd4;
  localparam logic [2:0] REG_BLEND_COEFF   = 3'd5;

  // Register values after reset.
  localparam logic [31:0] RST_GAIN_ANGLE    = 32'hFEA1_C852;
  localparam logic [31:0] RST_GAIN_RATE     = 32'hFFD0_C51F;
  localparam logic [31:0] RST_GAIN_SPEED    = 32'd486277;
  localparam logic [31:0] RST_GAIN_INTEGRAL = 32'd0;
  localparam logic [23:0] RST_ANGLE_OFFSET  = 24'd229376;
  localparam logic [15:0] RST_BLEND_COEFF   = 16'd64881;

  // Filter state after reset: three degrees in Q16.16.
  localparam logic signed [24:0] RST_FILTERED_ANGLE = 25'sd196608;

  // Fixed-point constants.
  localparam logic signed [22:0] DEG_PER_RAD   = 23'sd3755047;
  localparam logic signed [27:0] RAD_PER_DEG   = 28'sd74961321;
  localparam logic signed [24:0] ANGLE_LIMIT   = 25'sd11796480;
  localparam logic [12:0]        GYRO_HALF_DIV = 13'd7812;
  // Reciprocal of 15625 scaled by 2^52, rounded up; exact for 38-bit dividends.
  localparam logic [38:0]        GYRO_RECIP    = 39'd288230376152;

  // Depth of the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // One input item as it travels through the queue.
  typedef struct packed {
    logic [15:0] accel_x;
    logic [15:0] accel_y;
    logic [15:0] accel_z;
    logic [19:0] gyro_rate;
    logic [31:0] wheel_speed;
    logic [31:0] speed_ref;
    logic [15:0] elapsed_us;
  } in_item_t;

  // Configuration register file.
  typedef struct packed {
    logic [31:0] gain_angle;
    logic [31:0] gain_rate;
    logic [31:0] gain_speed;
    logic [31:0] gain_integral;
    logic [23:0] angle_offset;
    logic [15:0] blend_coeff;
  } cfg_t;

  // Arctangent table, atan(2^-i) in Q0.30.
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    case (idx)
      5'd0:    return 30'd843314857;
      5'd1:    return 30'd497837829;
      5'd2:    return 30'd263043837;
      5'd3:    return 30'd133525159;
      5'd4:    return 30'd67021687;
      5'd5:    return 30'd33543516;
      5'd6:    return 30'd16775851;
      5'd7:    return 30'd8388437;
      5'd8:    return 30'd4194283;
      5'd9:    return 30'd2097149;
      5'd10:   return 30'd1048575;
      5'd11:   return 30'd524288;
      5'd12:   return 30'd262144;
      5'd13:   return 30'd131072;
      5'd14:   return 30'd65536;
      5'd15:   return 30'd32768;
      5'd16:   return 30'd16384;
      5'd17:   return 30'd8192;
      5'd18:   return 30'd4096;
      5'd19:   return 30'd2048;
      5'd20:   return 30'd1024;
      5'd21:   return 30'd512;
      5'd22:   return 30'd256;
      5'd23:   return 30'd128;
      default: return 30'd0;
    endcase
  endfunction

endpackage

[rtl/tfl_front.sv]
// ----------------------------------------------------------------------------
// tfl_front
// Input side: takes stream transfers, unpacks them into items and holds
// them in a short queue for the back end.
// ----------------------------------------------------------------------------
module tfl_front
  import tfl_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,
  output logic         q_valid,
  input  logic         q_ready,
  output in_item_t     q_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  in_item_t        mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [PW:0]     count_r;
  in_item_t        item;
  logic            push;
  logic            pop;

  // Unpack the transfer, first field in the lowest bits.
  always_comb begin
    item.accel_x     = in_tdata[15:0];
    item.accel_y     = in_tdata[31:16];
    item.accel_z     = in_tdata[47:32];
    item.gyro_rate   = in_tdata[67:48];
    item.wheel_speed = in_tdata[99:68];
    item.speed_ref   = in_tdata[131:100];
    item.elapsed_us  = in_tdata[147:132];
  end

  assign in_tready = (count_r != (PW+1)'(QUEUE_DEPTH));
  assign q_valid   = (count_r != '0);
  assign q_item    = mem_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_valid && q_ready;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/tfl_div.sv]
// ----------------------------------------------------------------------------
// tfl_div
// Gyro step unit: rate times elapsed time times four, divided by 15625
// with the magnitude rounded to nearest, by reciprocal multiplication in
// four partial products.
// ----------------------------------------------------------------------------
module tfl_div
  import tfl_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [19:0] gyro_rate,
  input  logic [15:0]        elapsed_us,
  output logic               done,
  output logic signed [25:0] step
);

  logic [37:0]        mag_r;
  logic [76:0]        acc_r;
  logic [1:0]         cnt_r;
  logic               busy_r;
  logic               done_r;
  logic               neg_r;
  logic signed [38:0] num;
  logic signed [38:0] mag;
  logic [37:0]        dividend;
  logic [18:0]        op_n;
  logic [19:0]        op_m;
  logic [38:0]        pprod;
  logic [76:0]        pp_sh;
  logic signed [25:0] qv;

  // Dividend: magnitude of the scaled product plus half the divisor.
  always_comb begin
    num      = (39'(gyro_rate) * 39'(signed'({1'b0, elapsed_us}))) <<< 2;
    mag      = num[38] ? -num : num;
    dividend = 38'(mag) + 38'(GYRO_HALF_DIV);
  end

  // One partial product of dividend and reciprocal, aligned to its weight.
  always_comb begin
    op_n  = cnt_r[1] ? mag_r[37:19] : mag_r[18:0];
    op_m  = cnt_r[0] ? {1'b0, GYRO_RECIP[38:20]} : GYRO_RECIP[19:0];
    pprod = 39'(op_n) * 39'(op_m);
    case (cnt_r)
      2'd0:    pp_sh = 77'(pprod);
      2'd1:    pp_sh = 77'(pprod) << 20;
      2'd2:    pp_sh = 77'(pprod) << 19;
      default: pp_sh = 77'(pprod) << 39;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      neg_r  <= num[38];
      mag_r  <= dividend;
      acc_r  <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // The quotient is the product scaled down by 2^52.
  assign qv   = signed'({1'b0, acc_r[76:52]});
  assign step = neg_r ? -qv : qv;
  assign done = done_r;

endmodule

[rtl/tfl_core.sv]
// ----------------------------------------------------------------------------
// tfl_core
// Back end: accelerometer tilt by square root and CORDIC, complementary
// filter, speed integral and the four-term drive sum.
// ----------------------------------------------------------------------------
module tfl_core
  import tfl_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_valid,
  output logic               q_ready,
  input  in_item_t           q_item,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic signed [31:0] drive_cmd,
  output logic signed [24:0] tilt_angle,
  output logic               drive_saturated
);

  localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int AW = FRACTION_BITS + 3;
  localparam int DW = AW + 23;
  localparam int TS = 30 - FRACTION_BITS;
  localparam logic [31:0]          THALF = 32'd1 << (TS - 1);
  localparam logic signed [DW-1:0] DHALF = DW'(1) <<< (FRACTION_BITS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_CINIT, S_CORDIC, S_DEG, S_TILT, S_BLEND1, S_BLEND2,
    S_FILT, S_PHI, S_DPHI, S_RND, S_MUL, S_ACC, S_FIN
  } state_t;

  state_t                 state_r;
  in_item_t               item_r;
  logic [47:0]            sq_n_r;
  logic [26:0]            sq_rem_r;
  logic [23:0]            sq_root_r;
  logic [4:0]             sq_cnt_r;
  logic signed [26:0]     x_r;
  logic signed [26:0]     y_r;
  logic signed [AW-1:0]   ang_r;
  logic [IW-1:0]          step_r;
  logic                   zero_r;
  logic signed [DW-1:0]   deg_prod_r;
  logic signed [24:0]     tilt_r;
  logic signed [43:0]     p1_r;
  logic signed [42:0]     p2_r;
  logic signed [24:0]     fa_r;
  logic signed [39:0]     ses_r;
  logic                   sat_int_r;
  logic signed [53:0]     phi_prod_r;
  logic signed [47:0]     dphi_prod_r;
  logic signed [21:0]     phi_r;
  logic signed [23:0]     dphi_r;
  logic [2:0]             mac_cnt_r;
  logic signed [52:0]     mprod_r;
  logic signed [75:0]     acc_r;
  logic                   out_valid_r;
  logic signed [31:0]     out_drive_r;
  logic signed [24:0]     out_tilt_r;
  logic                   out_sat_r;

  logic                   pop;
  logic                   div_done;
  logic signed [25:0]     div_step;
  logic signed [32:0]     sq_sum;
  logic [26:0]            rem_sh;
  logic [26:0]            trial;
  logic                   root_bit;
  logic [31:0]            t_full;
  logic signed [AW-1:0]   t_ang;
  logic signed [26:0]     xs;
  logic signed [26:0]     ys;
  logic signed [DW-1:0]   deg_rnd;
  logic signed [26:0]     fs;
  logic [16:0]            wc;
  logic signed [44:0]     blended;
  logic signed [44:0]     bl_rnd;
  logic signed [24:0]     fa_new;
  logic signed [41:0]     int_sum;
  logic signed [39:0]     int_new;
  logic                   int_clip;
  logic signed [25:0]     off_angle;
  logic signed [53:0]     phi_rnd;
  logic signed [47:0]     dphi_rnd;
  logic signed [32:0]     ref_plus;
  logic signed [39:0]     mac_v;
  logic signed [31:0]     mac_k;
  logic signed [20:0]     chunk;
  logic signed [75:0]     u_full;
  logic signed [31:0]     u_sat;
  logic                   u_clip;

  assign q_ready = (state_r == S_IDLE);
  assign pop     = q_valid && q_ready;

  tfl_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (pop),
    .gyro_rate  ($signed(q_item.gyro_rate)),
    .elapsed_us (q_item.elapsed_us),
    .done       (div_done),
    .step       (div_step)
  );

  // Sum of the squared horizontal axes.
  assign sq_sum = 33'($signed(q_item.accel_x) * $signed(q_item.accel_x))
                + 33'($signed(q_item.accel_y) * $signed(q_item.accel_y));

  // One digit of the integer square root.
  always_comb begin
    rem_sh   = {sq_rem_r[24:0], sq_n_r[47:46]};
    trial    = {1'b0, sq_root_r, 2'b01};
    root_bit = (rem_sh >= trial);
  end

  // One CORDIC vectoring step with the rounded table angle.
  always_comb begin
    t_full = ({2'b00, atan_q30(5'(step_r))} + THALF) >> TS;
    t_ang  = signed'(AW'(t_full));
    xs     = x_r >>> step_r;
    ys     = y_r >>> step_r;
  end

  // Tilt in degrees, filter blend and the speed integral.
  always_comb begin
    deg_rnd = (deg_prod_r + DHALF) >>> FRACTION_BITS;
    fs      = 27'(fa_r) + 27'(div_step);
    wc      = 17'h10000 - {1'b0, cfg.blend_coeff};
    blended = 45'(p1_r) + 45'(p2_r);
    bl_rnd  = (blended + 45'sd32768) >>> 16;
    if (bl_rnd > 45'(ANGLE_LIMIT)) begin
      fa_new = ANGLE_LIMIT;
    end else if (bl_rnd < -45'(ANGLE_LIMIT)) begin
      fa_new = -ANGLE_LIMIT;
    end else begin
      fa_new = bl_rnd[24:0];
    end
    int_sum = 42'(ses_r) + 42'($signed(item_r.speed_ref))
            - 42'($signed(item_r.wheel_speed));
    if (int_sum > 42'sd549755813887) begin
      int_new  = 40'sh7F_FFFF_FFFF;
      int_clip = 1'b1;
    end else if (int_sum < -42'sd549755813888) begin
      int_new  = 40'sh80_0000_0000;
      int_clip = 1'b1;
    end else begin
      int_new  = int_sum[39:0];
      int_clip = 1'b0;
    end
  end

  // Angle and rate in radians.
  always_comb begin
    off_angle = 26'(fa_r) + 26'($signed(cfg.angle_offset));
    phi_rnd   = (phi_prod_r + 54'sd2147483648) >>> 32;
    dphi_rnd  = (dphi_prod_r + 48'sd8388608) >>> 24;
    ref_plus  = 33'($signed(item_r.speed_ref)) + 33'($signed(item_r.wheel_speed));
  end

  // Operand selection for the shared drive multiplier.
  always_comb begin
    case (mac_cnt_r[2:1])
      2'd0: begin
        mac_v = 40'(phi_r);
        mac_k = $signed(cfg.gain_angle);
      end
      2'd1: begin
        mac_v = 40'(dphi_r);
        mac_k = $signed(cfg.gain_rate);
      end
      2'd2: begin
        mac_v = 40'(ref_plus);
        mac_k = $signed(cfg.gain_speed);
      end
      default: begin
        mac_v = ses_r;
        mac_k = $signed(cfg.gain_integral);
      end
    endcase
    // The upper chunk carries the sign, the lower one is unsigned.
    chunk = mac_cnt_r[0] ? 21'($signed(mac_v[39:20])) : signed'({1'b0, mac_v[19:0]});
  end

  // Final rounding and saturation of the drive.
  always_comb begin
    u_full = (acc_r + 76'sd32768) >>> 16;
    if (u_full > 76'sd2147483647) begin
      u_sat  = 32'sh7FFF_FFFF;
      u_clip = 1'b1;
    end else if (u_full < -76'sd2147483648) begin
      u_sat  = 32'sh8000_0000;
      u_clip = 1'b1;
    end else begin
      u_sat  = u_full[31:0];
      u_clip = 1'b0;
    end
  end

  // Sequencer, datapath registers and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fa_r        <= RST_FILTERED_ANGLE;
      ses_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // A taken result empties the register unless the next one is loaded.
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (pop) begin
            item_r    <= q_item;
            sq_n_r    <= {sq_sum[31:0], 16'd0};
            sq_rem_r  <= '0;
            sq_root_r <= '0;
            sq_cnt_r  <= '0;
            state_r   <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_rem_r  <= root_bit ? rem_sh - trial : rem_sh;
          sq_root_r <= {sq_root_r[22:0], root_bit};
          sq_n_r    <= {sq_n_r[45:0], 2'b00};
          sq_cnt_r  <= sq_cnt_r + 1'b1;
          if (sq_cnt_r == 5'd23) begin
            state_r <= S_CINIT;
          end
        end
        S_CINIT: begin
          x_r     <= signed'({3'b000, sq_root_r});
          y_r     <= 27'($signed(item_r.accel_z)) <<< 8;
          ang_r   <= '0;
          step_r  <= '0;
          zero_r  <= (sq_root_r == '0) && (item_r.accel_z == '0);
          state_r <= S_CORDIC;
        end
        S_CORDIC: begin
          if (!y_r[26]) begin
            x_r   <= x_r + ys;
            y_r   <= y_r - xs;
            ang_r <= ang_r + t_ang;
          end else begin
            x_r   <= x_r - ys;
            y_r   <= y_r + xs;
            ang_r <= ang_r - t_ang;
          end
          step_r <= step_r + 1'b1;
          if (step_r == IW'(CORDIC_STEPS - 1)) begin
            state_r <= S_DEG;
          end
        end
        S_DEG: begin
          deg_prod_r <= DW'(ang_r) * DW'(DEG_PER_RAD);
          state_r    <= S_TILT;
        end
        S_TILT: begin
          tilt_r <= zero_r ? 25'sd0 : deg_rnd[24:0];
          if (div_done) begin
            state_r <= S_BLEND1;
          end
        end
        S_BLEND1: begin
          p1_r    <= 44'(fs) * 44'(signed'({1'b0, cfg.blend_coeff}));
          state_r <= S_BLEND2;
        end
        S_BLEND2: begin
          p2_r    <= 43'(tilt_r) * 43'(signed'({1'b0, wc}));
          state_r <= S_FILT;
        end
        S_FILT: begin
          fa_r      <= fa_new;
          ses_r     <= int_new;
          sat_int_r <= int_clip;
          state_r   <= S_PHI;
        end
        S_PHI: begin
          phi_prod_r <= 54'(off_angle) * 54'(RAD_PER_DEG);
          state_r    <= S_DPHI;
        end
        S_DPHI: begin
          dphi_prod_r <= 48'($signed(item_r.gyro_rate)) * 48'(RAD_PER_DEG);
          state_r     <= S_RND;
        end
        S_RND: begin
          phi_r     <= phi_rnd[21:0];
          dphi_r    <= dphi_rnd[23:0];
          acc_r     <= '0;
          mac_cnt_r <= '0;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          mprod_r <= 53'(mac_k) * 53'(chunk);
          state_r <= S_ACC;
        end
        S_ACC: begin
          acc_r     <= acc_r + (mac_cnt_r[0] ? (76'(mprod_r) <<< 20) : 76'(mprod_r));
          mac_cnt_r <= mac_cnt_r + 1'b1;
          state_r   <= (mac_cnt_r == 3'd7) ? S_FIN : S_MUL;
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_drive_r <= u_sat;
            out_tilt_r  <= fa_r;
            out_sat_r   <= sat_int_r || u_clip;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid      = out_valid_r;
  assign drive_cmd       = out_drive_r;
  assign tilt_angle      = out_tilt_r;
  assign drive_saturated = out_sat_r;

endmodule

[rtl/tilt_filter_lqr_balance_unit.sv]
// ----------------------------------------------------------------------------
// tilt_filter_lqr_balance_unit
// Balance controller: accelerometer tilt, complementary filter and
// four-gain drive law, one result per control tick.
// ----------------------------------------------------------------------------
// Usage. Each transfer on the in_ stream carries one control tick: three
// accelerometer axes, gyro rate, wheel speed, speed reference and elapsed
// time. Each tick gives exactly one transfer on the out_ stream with the
// drive command, the new filtered tilt and a saturation flag. Gains, angle
// offset and blend weight are written through the cfg_ port; the user must
// write them only while idle, as the block itself does not enforce this.
// One tick is worked at a time, through the 24-digit square root, the
// CORDIC loop at one step a cycle and eight passes through the shared 32
// by 21 drive multiplier; the gyro divider runs beside the square root. A
// two-entry queue takes further ticks while one is at work. The result
// waits in an output register if the receiver stalls; the next tick may
// finish its arithmetic meanwhile and waits only at that register. Reset
// clears the queue and the output, restores the register defaults, sets
// the filtered angle to three degrees and the speed integral to zero.
// ----------------------------------------------------------------------------
module tilt_filter_lqr_balance_unit
  import tfl_pkg::*;
#(
  parameter int CORDIC_STEPS  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  // accel_x, accel_y, accel_z, gyro_rate, wheel_speed, speed_ref, elapsed_us
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [151:0] in_tdata,
  // drive_cmd, tilt_angle
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,
  // drive_saturated
  output logic         out_tuser,
  input  logic         cfg_wr_en,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_wdata
);

  cfg_t               cfg_r;
  logic               q_valid;
  logic               q_ready;
  in_item_t           q_item;
  logic signed [31:0] drive_cmd;
  logic signed [24:0] tilt_angle;
  logic               drive_saturated;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_angle    <= RST_GAIN_ANGLE;
      cfg_r.gain_rate     <= RST_GAIN_RATE;
      cfg_r.gain_speed    <= RST_GAIN_SPEED;
      cfg_r.gain_integral <= RST_GAIN_INTEGRAL;
      cfg_r.angle_offset  <= RST_ANGLE_OFFSET;
      cfg_r.blend_coeff   <= RST_BLEND_COEFF;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_GAIN_ANGLE:    cfg_r.gain_angle    <= cfg_wdata;
        REG_GAIN_RATE:     cfg_r.gain_rate     <= cfg_wdata;
        REG_GAIN_SPEED:    cfg_r.gain_speed    <= cfg_wdata;
        REG_GAIN_INTEGRAL: cfg_r.gain_integral <= cfg_wdata;
        REG_ANGLE_OFFSET:  cfg_r.angle_offset  <= cfg_wdata[23:0];
        REG_BLEND_COEFF:   cfg_r.blend_coeff   <= cfg_wdata[15:0];
        default: begin
        end
      endcase
    end
  end

  tfl_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_item    (q_item)
  );

  tfl_core #(
    .CORDIC_STEPS  (CORDIC_STEPS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_core (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_ready         (q_ready),
    .q_item          (q_item),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .drive_cmd       (drive_cmd),
    .tilt_angle      (tilt_angle),
    .drive_saturated (drive_saturated)
  );

  // Result packing, first field in the lowest bits.
  assign out_tdata = {7'd0, tilt_angle, drive_cmd};
  assign out_tuser = drive_saturated;

  // Reset leaves no result on the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The reported tilt never leaves the clamp range.
  a_tilt_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[56:32]) <= ANGLE_LIMIT &&
                    $signed(out_tdata[56:32]) >= -ANGLE_LIMIT))
    else $error("tilt outside clamp range");

  // A stalled result stays offered and unchanged until it is taken.
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
                                  $stable(out_tuser))
    else $error("stalled result changed");

endmodule

[bench/tb_tilt_filter_lqr_balance_unit.sv]
// ----------------------------------------------------------------------------
// tb_tilt_filter_lqr_balance_unit
// Self-checking testbench for the balance controller. Every control tick
// that is sent is also run through a bit-exact predictor in the bench:
// the accelerometer CORDIC tilt, the complementary filter, the speed
// integral and the four-gain drive law. Each result transfer is compared,
// field by field, with the oldest prediction. Both sides idle at random,
// and one phase holds the result side off for a long stretch.
// ----------------------------------------------------------------------------
module tb_tilt_filter_lqr_balance_unit;
  import tfl_pkg::*;

  localparam logic [2:0] REG_UNUSED_A = 3'd6;
  localparam logic [2:0] REG_UNUSED_B = 3'd7;
  localparam int         SETTLE       = 90;
  localparam longint     CYCLE_LIMIT  = 1500000;
  localparam longint     ANG_MAX      = 11796480;
  localparam longint     SUM_HI       = 64'sd549755813887;
  localparam longint     SUM_LO       = -64'sd549755813888;

  typedef struct {
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [19:0] gyro;
    logic signed [31:0] speed;
    logic signed [31:0] sref;
    logic [15:0]        dt;
  } tick_t;

  typedef struct {
    logic signed [31:0] drive;
    logic signed [24:0] tilt;
    logic               sat;
  } drive_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [151:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_wr_en = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  // Predictor copy of the registers and the controller state.
  logic signed [31:0] k_angle, k_rate, k_speed, k_integ;
  logic signed [23:0] offs_deg;
  logic [15:0]        blend_w;
  longint             angle_state;
  longint             integ_state;

  drive_res_t expected_drive[$];
  int         mismatches = 0;
  longint     cycles = 0;
  int         hold_off = 0;
  bit         no_idle = 1'b0;

  longint atan_tab[16] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                           33543516, 16775851, 8388437, 4194283, 2097149, 1048575,
                           524288, 262144, 131072, 65536, 32768};

  tilt_filter_lqr_balance_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock: period of 12.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Round half up, then arithmetic shift.
  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // Accelerometer tilt by CORDIC vectoring, in Q16.16 degrees.
  function automatic longint accel_tilt(longint ax, longint ay, longint az);
    longint x, y, ang, t, xs, ys;
    x = int_sqrt(longint'(ax * ax + ay * ay) << 16);
    y = az * 256;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 16; i++) begin
      t = round_shift(atan_tab[i], 14);
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; ang += t;
      end else begin
        x -= ys; y += xs; ang -= t;
      end
    end
    return round_shift(ang * 3755047, 16);
  endfunction

  // Q16.16 multiply-accumulate keeping the dropped fraction separately.
  function automatic void q16_mac(longint k, longint v, inout longint ip, inout longint fp);
    longint vh, vl, p, ph;
    vh = v >>> 16;
    vl = v - vh * 65536;
    p = k * vl;
    ph = p >>> 16;
    ip += k * vh + ph;
    fp += p - ph * 65536;
  endfunction

  // One control tick: updates the filter and integral, returns the result.
  function automatic drive_res_t balance_tick(tick_t t);
    drive_res_t r;
    longint gyro, dt, num, step, w, phi, dphi, sum, ip, fp, u, tilt;
    bit sat;
    gyro = t.gyro;
    dt = t.dt;
    w = blend_w;
    sat = 1'b0;
    ip = 0;
    fp = 0;
    tilt = accel_tilt(t.ax, t.ay, t.az);
    num = gyro * dt * 4;
    if (num >= 0) step = (num + 7812) / 15625;
    else step = -((-num + 7812) / 15625);
    angle_state = round_shift(w * (angle_state + step) + (65536 - w) * tilt, 16);
    if (angle_state > ANG_MAX) angle_state = ANG_MAX;
    if (angle_state < -ANG_MAX) angle_state = -ANG_MAX;
    phi = round_shift((angle_state + longint'(offs_deg)) * 74961321, 32);
    dphi = round_shift(gyro * 74961321, 24);
    sum = integ_state + longint'(t.sref) - longint'(t.speed);
    if (sum > SUM_HI) begin sum = SUM_HI; sat = 1'b1; end
    if (sum < SUM_LO) begin sum = SUM_LO; sat = 1'b1; end
    integ_state = sum;
    q16_mac(k_angle, phi, ip, fp);
    q16_mac(k_rate, dphi, ip, fp);
    q16_mac(k_speed, longint'(t.sref) + longint'(t.speed), ip, fp);
    q16_mac(k_integ, integ_state, ip, fp);
    u = ip + ((fp + 32768) >>> 16);
    if (u > 64'sd2147483647) begin u = 64'sd2147483647; sat = 1'b1; end
    if (u < -64'sd2147483648) begin u = -64'sd2147483648; sat = 1'b1; end
    r.drive = u[31:0];
    r.tilt = angle_state[24:0];
    r.sat = sat;
    return r;
  endfunction

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tilt_filter_lqr_balance_unit: mismatch");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off counted here.
  always @(negedge clk) begin
    if (rst_n && hold_off > 0) begin
      out_tready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 24);
    end
  end

  // Result check against the oldest prediction.
  always @(posedge clk) begin
    drive_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_drive.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transfer: drive %0d tilt %0d sat %0b",
                   $signed(out_tdata[31:0]), $signed(out_tdata[56:32]), out_tuser);
      end else begin
        e = expected_drive.pop_front();
        if (out_tdata[31:0] !== e.drive || out_tdata[56:32] !== e.tilt
            || out_tdata[63:57] !== 7'd0 || out_tuser !== e.sat) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result differs: drive %0d/%0d tilt %0d/%0d sat %0b/%0b (exp/act)",
                     e.drive, $signed(out_tdata[31:0]), e.tilt,
                     $signed(out_tdata[56:32]), e.sat, out_tuser);
        end
      end
    end
  end

  // Sends one tick; the prediction is made when the transfer happens.
  task automatic send_tick(tick_t t);
    int gap;
    if (!no_idle && $urandom_range(99) < 24) begin
      gap = $urandom_range(4, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, t.dt, t.sref, t.speed, t.gyro, t.az, t.ay, t.ax};
    do @(posedge clk); while (!in_tready);
    expected_drive.push_back(balance_tick(t));
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (expected_drive.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writes all six registers, then the two unused indexes, which are ignored.
  task automatic write_regs(logic [31:0] ka, logic [31:0] kr, logic [31:0] ks,
                            logic [31:0] ki, logic [23:0] offs, logic [15:0] w);
    logic [31:0] vals[6];
    logic [2:0]  idx[6];
    vals = '{ka, kr, ks, ki, {8'd0, offs}, {16'd0, w}};
    idx = '{REG_GAIN_ANGLE, REG_GAIN_RATE, REG_GAIN_SPEED, REG_GAIN_INTEGRAL,
            REG_ANGLE_OFFSET, REG_BLEND_COEFF};
    for (int i = 0; i < 6; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= vals[i] | (i >= 4 ? 32'hA500_0000 : 32'd0);
      @(negedge clk);
    end
    cfg_index <= REG_UNUSED_A;
    cfg_wdata <= 32'h1234_5678;
    @(negedge clk);
    cfg_index <= REG_UNUSED_B;
    cfg_wdata <= 32'hFFFF_FFFF;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    k_angle = ka;
    k_rate = kr;
    k_speed = ks;
    k_integ = ki;
    offs_deg = offs;
    blend_w = w;
  endtask

  function automatic tick_t mk_tick(int ax, int ay, int az, int gyro,
                                    longint speed, longint sref, int dt);
    tick_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az); t.gyro = 20'(gyro);
    t.speed = 32'(speed); t.sref = 32'(sref); t.dt = 16'(dt);
    return t;
  endfunction

  // Mostly plausible sensor readings; some ticks are fully random.
  function automatic tick_t rand_tick();
    tick_t t;
    if ($urandom_range(99) < 25) begin
      t.ax = 16'($urandom); t.ay = 16'($urandom); t.az = 16'($urandom);
      t.gyro = 20'($urandom);
      t.speed = $urandom; t.sref = $urandom; t.dt = 16'($urandom);
    end else begin
      t.ax = 16'(int'($urandom_range(8000)) - 4000);
      t.ay = 16'(int'($urandom_range(2000)) - 1000);
      t.az = 16'(int'($urandom_range(32000)) - 16000);
      t.gyro = 20'(int'($urandom_range(40000)) - 20000);
      t.speed = int'($urandom_range(2000000)) - 1000000;
      t.sref = int'($urandom_range(200000)) - 100000;
      t.dt = 16'($urandom_range(4100, 3900));
    end
    return t;
  endfunction

  task automatic test_directed;
    send_tick(mk_tick(0, 0, 0, 0, 0, 0, 4000));
    send_tick(mk_tick(0, 0, 0, 1000, 0, 0, 0));
    send_tick(mk_tick(-32768, -32768, -32768, 0, 0, 0, 4000));
    send_tick(mk_tick(32767, 32767, 32767, 0, 0, 0, 4000));
    send_tick(mk_tick(0, 0, 16384, 0, 0, 0, 4000));
    send_tick(mk_tick(0, 0, -16384, 0, 0, 0, 4000));
    send_tick(mk_tick(16384, 0, 0, 0, 0, 0, 4000));
    send_tick(mk_tick(-16384, 0, 0, 0, 0, 0, 4000));
    // Gyro extremes over the longest interval drive the angle to its limits.
    repeat (3) send_tick(mk_tick(0, 0, 16384, 524287, 0, 0, 65535));
    repeat (4) send_tick(mk_tick(0, 0, -16384, -524288, 0, 0, 65535));
    send_tick(mk_tick(100, 50, 16000, 0, 64'sd2147483647, 64'sd2147483647, 4000));
    send_tick(mk_tick(100, 50, 16000, 0, -64'sd2147483648, -64'sd2147483648, 4000));
    send_tick(mk_tick(100, 50, 16000, 0, -64'sd2147483648, 64'sd2147483647, 4000));
    send_tick(mk_tick(100, 50, 16000, 0, 64'sd2147483647, -64'sd2147483648, 4000));
    send_tick(mk_tick(1, -1, 1, -1, 1, -1, 1));
    drain();
  endtask

  // A run of identical large errors pushes the integral into saturation.
  task automatic test_integral_limit;
    write_regs(32'd65536, 32'd0, 32'd0, 32'd1, 24'd0, 16'd32768);
    repeat (140) send_tick(mk_tick(0, 0, 16384, 0, -64'sd2147483648,
                                   64'sd2147483647, 4000));
    repeat (140) send_tick(mk_tick(0, 0, 16384, 0, 64'sd2147483647,
                                   -64'sd2147483648, 4000));
    drain();
  endtask

  task automatic test_random_phase(int n);
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 3 && i < n / 2);
      send_tick(rand_tick());
    end
    no_idle = 1'b0;
    drain();
  endtask

  // Long receiver hold-off while ticks keep coming, so the input stalls.
  task automatic test_backpressure;
    hold_off = 1500;
    no_idle = 1'b1;
    repeat (30) send_tick(rand_tick());
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_config_sweep;
    write_regs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               24'h7FFFFF, 16'd65535);
    test_random_phase(200);
    write_regs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               24'h800000, 16'd0);
    test_random_phase(200);
    write_regs($urandom, $urandom, $urandom, $urandom, 24'(-5898240), 16'd1);
    test_random_phase(200);
    write_regs(-32'sd22951854, -32'sd3095265, 32'd486277, 32'd40000,
               24'd5898240, 16'd64881);
    test_random_phase(300);
  endtask

  initial begin
    k_angle = RST_GAIN_ANGLE;
    k_rate = RST_GAIN_RATE;
    k_speed = RST_GAIN_SPEED;
    k_integ = RST_GAIN_INTEGRAL;
    offs_deg = RST_ANGLE_OFFSET;
    blend_w = RST_BLEND_COEFF;
    angle_state = 196608;
    integ_state = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_phase(420);
    test_backpressure();
    test_integral_limit();
    test_config_sweep();
    if (mismatches == 0 && expected_drive.size() == 0) begin
      $display("tilt_filter_lqr_balance_unit: match");
    end else begin
      $display("tilt_filter_lqr_balance_unit: mismatch");
    end
    $finish;
  end

endmodule
